// ===== src/b64d_pkg.sv =====
// Package for the Base64 stream decoder.
// Holds the result type, the character codes and the character-to-sextet map.
// No dependencies.
package b64d_pkg;

	localparam int CharW  = 8;
	localparam int SextW  = 6;
	localparam int ByteW  = 8;
	localparam int CountW = 2;
	localparam int PosW   = 2;
	localparam int OutDataW = 32;

	localparam logic [CharW-1:0] ChPad   = 8'h3d; // '='
	localparam logic [CharW-1:0] ChPlus  = 8'h2b; // '+'
	localparam logic [CharW-1:0] ChMinus = 8'h2d; // '-'
	localparam logic [CharW-1:0] ChSlash = 8'h2f; // '/'
	localparam logic [CharW-1:0] ChUnder = 8'h5f; // '_'
	localparam logic [CharW-1:0] ChUpA   = 8'h41;
	localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
	localparam logic [CharW-1:0] ChLoA   = 8'h61;
	localparam logic [CharW-1:0] ChLoZ   = 8'h7a;
	localparam logic [CharW-1:0] ChDig0  = 8'h30;
	localparam logic [CharW-1:0] ChDig9  = 8'h39;

	localparam logic [SextW-1:0] SextPlus  = 6'd62;
	localparam logic [SextW-1:0] SextSlash = 6'd63;
	localparam logic [CountW-1:0] CountFull = 2'd3;
	localparam logic [PosW-1:0] PosLast = 2'd3;

	typedef struct packed {
		logic [ByteW-1:0]  byte_first;
		logic [ByteW-1:0]  byte_second;
		logic [ByteW-1:0]  byte_third;
		logic [CountW-1:0] byte_count;
		logic              stream_end;
	} b64d_result_t;

	function automatic logic [SextW-1:0] char_to_sextet(input logic [CharW-1:0] c);
		logic [CharW-1:0] d;
		d = '0;
		if (c >= ChUpA && c <= ChUpZ) begin
			d = c - ChUpA;
		end else if (c >= ChLoA && c <= ChLoZ) begin
			d = c - ChLoA + 8'd26;
		end else if (c >= ChDig0 && c <= ChDig9) begin
			d = c - ChDig0 + 8'd52;
		end else if (c == ChPlus || c == ChMinus) begin
			d = {2'b00, SextPlus};
		end else if (c == ChSlash || c == ChUnder) begin
			d = {2'b00, SextSlash};
		end
		return d[SextW-1:0];
	endfunction

endpackage

// ===== src/b64d_group.sv =====
// Group assembler: tracks the position in the four-character group,
// stores sextets and forms the result of a closing group.
// Depends on b64d_pkg.
module b64d_group (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     beat,
	input  logic [7:0]               char_code,
	input  logic                     is_final,
	output logic                     res_valid,
	output b64d_pkg::b64d_result_t   res
);
	import b64d_pkg::*;

	logic [PosW-1:0]  pos_q;
	logic [SextW-1:0] store_q [3];
	logic [PosW-1:0]  pad_q;

	logic [SextW-1:0] v;
	logic [SextW-1:0] s [3];
	logic [SextW-1:0] s3;
	logic [PosW-1:0]  pad_next;
	logic [CountW-1:0] count;
	logic [ByteW-1:0] b0, b1, b2;

	always_comb begin
		v = char_to_sextet(char_code);
		pad_next = pad_q;
		if (char_code == ChPad && pos_q != '0 && pad_q == '0) pad_next = pos_q;
		for (int i = 0; i < 3; i++) begin
			s[i] = (pos_q == PosW'(i)) ? v : store_q[i];
		end
		s3 = (pos_q == PosLast) ? v : '0;
		res_valid = is_final || pos_q == PosLast;
		if (is_final) begin
			count = pos_q;
			if (pad_next != '0 && (pad_next - 2'd1) < count) count = pad_next - 2'd1;
		end else begin
			count = CountFull;
		end
		b0 = {s[0], s[1][5:4]};
		b1 = {s[1][3:0], s[2][5:2]};
		b2 = {s[2][1:0], s3};
		res.byte_first  = (count >= 2'd1) ? b0 : '0;
		res.byte_second = (count >= 2'd2) ? b1 : '0;
		res.byte_third  = (count == 2'd3) ? b2 : '0;
		res.byte_count  = count;
		res.stream_end  = is_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pad_q <= '0;
			for (int i = 0; i < 3; i++) store_q[i] <= '0;
		end else if (beat) begin
			if (res_valid) begin
				pos_q <= '0;
				pad_q <= '0;
				for (int i = 0; i < 3; i++) store_q[i] <= '0;
			end else begin
				pos_q <= pos_q + 2'd1;
				pad_q <= pad_next;
				for (int i = 0; i < 3; i++) store_q[i] <= s[i];
			end
		end
	end

endmodule

// ===== src/base64_stream_decoder_unit.sv =====
// Top level of the Base64 stream decoder: input stream, group assembler,
// output register with skid stage.
// Depends on b64d_pkg and b64d_group.
//
// Usage:
//   s_axis carries one ASCII character per beat in s_tdata; s_tlast marks the
//   last character of an encoded string. Standard and URL-safe alphabets are
//   both decoded; any other character counts as zero.
//   m_axis carries one beat per closed four-character group, or per end of
//   string: three bytes and a byte count in m_tdata, and m_tlast set on the
//   beat that closes the string.
// Output: the result of a group is registered in the output stage, or in the
//   skid stage while that is stalled, at the edge that takes its closing character.
// Throughput: one character per cycle while s_tready is high; the group state and
//   the output or skid register update at the edge that takes the character.
// Reset: arst_n clears the group state and both output stages; the next
//   character starts a new string.
// Stall: while m_tready is low, one further result is held in the skid
//   stage; s_tready drops only when the skid stage is full.
module base64_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // is_final
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] byte_first, [15:8] byte_second,
	                               // [23:16] byte_third, [25:24] byte_count, zeros
	output logic        m_tlast    // stream_end
);
	import b64d_pkg::*;

	logic         in_beat;
	logic         res_valid;
	b64d_result_t res;
	logic         res_beat;

	logic         out_valid_q;
	b64d_result_t out_q;
	logic         skid_valid_q;
	b64d_result_t skid_q;

	assign s_tready = !skid_valid_q;
	assign in_beat  = s_tvalid && s_tready;
	assign res_beat = in_beat && res_valid;

	b64d_group u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (in_beat),
		.char_code (s_tdata),
		.is_final  (s_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_beat;
			end
		end else if (res_beat) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (res_beat) out_q <= res;
		end else if (res_beat) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutDataW - 3*ByteW - CountW){1'b0}}, out_q.byte_count,
	                   out_q.byte_third, out_q.byte_second, out_q.byte_first};
	assign m_tlast  = out_q.stream_end;

	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a beat while the output stage is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[25:24] == CountFull))
		else $error("non-final group gave fewer than three bytes");

endmodule
